### rtl/core/isotp_message_segmenter_macros.svh
// ----------------------------------------------------------------------------
// ISO-TP segmenter assertion macros
// Shared concurrent assertion forms for the segmenter RTL.
// ----------------------------------------------------------------------------
`ifndef ISOTP_MESSAGE_SEGMENTER_MACROS_SVH
`define ISOTP_MESSAGE_SEGMENTER_MACROS_SVH

// Checked at every rising edge of i_clk, suspended while reset is asserted.
`define SEG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define SEG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/isotp_seg_pkg.sv
// ----------------------------------------------------------------------------
// ISO-TP segmenter package
// Types, frame codes and the payload builder shared by the segmenter files.
// ----------------------------------------------------------------------------
package isotp_seg_pkg;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_FIRST  = 2'd1;
    localparam logic [1:0] KIND_CONSEC = 2'd2;

    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;

    localparam logic [7:0] PAD_RESET    = 8'hAA;
    localparam logic [2:0] FILL_CONSEC  = 3'd7;
    localparam logic [2:0] FILL_FIRST   = 3'd6;
    localparam logic [11:0] SINGLE_MAX  = 12'd7;

    typedef struct packed {
        logic [11:0] bytes_taken;
        logic [3:0]  seq_number;
        logic [63:0] frame_assembly;
        logic [2:0]  fill_count;
        logic        first_sent;
    } t_seg_state;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [63:0] frame_payload;
        logic [1:0]  frame_kind;
        logic        last_frame;
    } t_frame;

    // Places the PCI bytes ahead of the waiting data and pads every byte
    // position at or beyond the used count.
    function automatic logic [63:0] build_payload(
        input logic        two_byte_pci,
        input logic [15:0] pci,
        input logic [63:0] assembly,
        input logic [3:0]  used,
        input logic [7:0]  pad
    );
        logic [63:0] payload;
        if (two_byte_pci) begin
            payload = {pci, assembly[63:16]};
        end else begin
            payload = {pci[7:0], assembly[63:8]};
        end
        for (int pos = 0; pos < 8; pos++) begin
            if (4'(pos) >= used) begin
                payload[63 - 8*pos -: 8] = pad;
            end
        end
        return payload;
    endfunction

endpackage

### rtl/core/isotp_seg_cfg.sv
// ----------------------------------------------------------------------------
// ISO-TP segmenter configuration registers
// APB-style register file holding the pad byte.
// ----------------------------------------------------------------------------
module isotp_seg_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_pad_byte
);

    logic [7:0] r_pad_byte;
    logic [7:0] n_pad_byte;
    logic       pad_sel;

    assign pad_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;

    always_comb begin
        n_pad_byte = r_pad_byte;
        if (psel && penable && pwrite && pad_sel) begin
            n_pad_byte = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_byte <= isotp_seg_pkg::PAD_RESET;
        end else begin
            r_pad_byte <= n_pad_byte;
        end
    end

    assign prdata     = pad_sel ? {24'd0, r_pad_byte} : 32'd0;
    assign o_pad_byte = r_pad_byte;

endmodule

### rtl/core/isotp_seg_step.sv
// ----------------------------------------------------------------------------
// ISO-TP segmenter step logic
// Packs one message byte into the frame under assembly and decides whether a
// single, first or consecutive frame leaves, giving the next segmenter state.
// ----------------------------------------------------------------------------
module isotp_seg_step (
    input  isotp_seg_pkg::t_seg_state i_state,
    input  logic [7:0]                i_data_byte,
    input  logic [11:0]               i_msg_length,
    input  logic [10:0]               i_tx_id,
    input  logic [7:0]                i_pad_byte,
    output isotp_seg_pkg::t_seg_state o_next_state,
    output logic                      o_fire,
    output isotp_seg_pkg::t_frame     o_frame
);

    isotp_seg_pkg::t_seg_state idle_state;
    isotp_seg_pkg::t_seg_state accum_state;
    logic [63:0] assembly;
    logic [5:0]  shift;
    logic [3:0]  count;
    logic        is_last;
    logic [11:0] taken_inc;

    always_comb begin
        idle_state                = '0;
        idle_state.seq_number     = 4'd1;

        shift     = 6'd56 - {i_state.fill_count, 3'b000};
        assembly  = i_state.frame_assembly | ({56'd0, i_data_byte} << shift);
        count     = {1'b0, i_state.fill_count} + 4'd1;
        is_last   = ({1'b0, i_state.bytes_taken} + 13'd1) >= {1'b0, i_msg_length};
        taken_inc = i_state.bytes_taken + 12'd1;

        accum_state                = i_state;
        accum_state.frame_assembly = assembly;
        accum_state.fill_count     = count[2:0];
        accum_state.bytes_taken    = taken_inc;
    end

    always_comb begin
        o_next_state           = i_state;
        o_fire                 = 1'b0;
        o_frame.frame_id       = i_tx_id;
        o_frame.frame_kind     = isotp_seg_pkg::KIND_SINGLE;
        o_frame.last_frame     = 1'b0;
        o_frame.frame_payload  = isotp_seg_pkg::build_payload(1'b0,
            {8'd0, i_msg_length[7:0]}, assembly, count + 4'd1, i_pad_byte);

        if (i_msg_length != 12'd0) begin
            if (!i_state.first_sent && (i_msg_length <= isotp_seg_pkg::SINGLE_MAX)) begin
                if (is_last) begin
                    o_fire             = 1'b1;
                    o_frame.last_frame = 1'b1;
                    o_next_state       = idle_state;
                end else begin
                    o_next_state = accum_state;
                end
            end else if (!i_state.first_sent) begin
                if (count >= {1'b0, isotp_seg_pkg::FILL_FIRST}) begin
                    o_fire                = 1'b1;
                    o_frame.frame_kind    = isotp_seg_pkg::KIND_FIRST;
                    o_frame.frame_payload = isotp_seg_pkg::build_payload(1'b1,
                        {isotp_seg_pkg::PCI_FIRST, i_msg_length}, assembly, 4'd8,
                        i_pad_byte);
                    o_next_state.first_sent  = 1'b1;
                    o_next_state.seq_number  = 4'd1;
                    o_next_state.bytes_taken = taken_inc;
                    if (count == {1'b0, isotp_seg_pkg::FILL_CONSEC}) begin
                        o_next_state.frame_assembly = {i_data_byte, 56'd0};
                        o_next_state.fill_count     = 3'd1;
                    end else begin
                        o_next_state.frame_assembly = '0;
                        o_next_state.fill_count     = 3'd0;
                    end
                end else begin
                    o_next_state = accum_state;
                end
            end else begin
                if ((count == {1'b0, isotp_seg_pkg::FILL_CONSEC}) || is_last) begin
                    o_fire                = 1'b1;
                    o_frame.frame_kind    = isotp_seg_pkg::KIND_CONSEC;
                    o_frame.last_frame    = is_last;
                    o_frame.frame_payload = isotp_seg_pkg::build_payload(1'b0,
                        {8'd0, isotp_seg_pkg::PCI_CONSEC, i_state.seq_number},
                        assembly, count + 4'd1, i_pad_byte);
                    if (is_last) begin
                        o_next_state = idle_state;
                    end else begin
                        o_next_state.seq_number     = i_state.seq_number + 4'd1;
                        o_next_state.frame_assembly = '0;
                        o_next_state.fill_count     = 3'd0;
                        o_next_state.bytes_taken    = taken_inc;
                    end
                end else begin
                    o_next_state = accum_state;
                end
            end
        end
    end

endmodule

### rtl/core/isotp_message_segmenter.sv
// ----------------------------------------------------------------------------
// ISO-TP message segmenter
// Turns a message, one byte per transfer, into ISO 15765-2 CAN frames.
//
//   Channel   Direction  Handshake          Contents
//   input     in         i_valid/o_ready    data_byte, msg_length, tx_id
//   frame     out        o_valid/i_ready    frame_id, payload, kind, last
//   config    in         APB psel/penable   pad_byte at address 0
//
// A byte is taken every cycle while o_ready is high; its frame, if any, appears in
// the output register in the cycle after, set by the single pass through the step logic.
// A pending frame that is not taken stalls input until it is taken, whether
// or not the new byte would produce a frame; o_ready follows the output register.
// Synchronous active-low reset empties the output and starts a new message.
// ----------------------------------------------------------------------------
`include "isotp_message_segmenter_macros.svh"

module isotp_message_segmenter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [11:0] i_msg_length,
    input  logic [10:0] i_tx_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_frame_id,
    output logic [63:0] o_frame_payload,
    output logic [1:0]  o_frame_kind,
    output logic        o_last_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                      accept;
    logic [7:0]                pad_byte;
    logic                      step_fire;
    isotp_seg_pkg::t_seg_state step_state;
    isotp_seg_pkg::t_frame     step_frame;

    isotp_seg_pkg::t_seg_state r_state;
    isotp_seg_pkg::t_frame     r_frame;
    logic                      r_out_valid;
    logic                      n_out_valid;

    logic                      counts_agree;
    logic                      frame_ends;
    logic                      state_idle;

    isotp_seg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_pad_byte (pad_byte)
    );

    isotp_seg_step u_step (
        .i_state      (r_state),
        .i_data_byte  (i_data_byte),
        .i_msg_length (i_msg_length),
        .i_tx_id      (i_tx_id),
        .i_pad_byte   (pad_byte),
        .o_next_state (step_state),
        .o_fire       (step_fire),
        .o_frame      (step_frame)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = step_fire;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{bytes_taken: 12'd0, seq_number: 4'd1, frame_assembly: 64'd0,
                             fill_count: 3'd0, first_sent: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_state <= step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step_fire) begin
            r_frame <= step_frame;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_id      = r_frame.frame_id;
    assign o_frame_payload = r_frame.frame_payload;
    assign o_frame_kind    = r_frame.frame_kind;
    assign o_last_frame    = r_frame.last_frame;

    assign counts_agree = r_state.first_sent
                          || (r_state.bytes_taken == {9'd0, r_state.fill_count});
    assign frame_ends   = accept && step_fire && step_frame.last_frame;
    assign state_idle   = (r_state.bytes_taken == 12'd0) && !r_state.first_sent
                          && (r_state.seq_number == 4'd1);

    `SEG_ASSERT(a_fill_bound, (r_state.fill_count <= 3'd6), "assembly fill overrun")

    `SEG_ASSERT(a_prefirst_count, counts_agree, "byte count and fill disagree before first frame")

    `SEG_ASSERT(a_end_clears, (frame_ends |=> state_idle), "message end did not restart state")

    `SEG_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

### tb/tb_isotp_message_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISO-TP message segmenter testbench
// Feeds messages one byte per transfer: single frames, multi-frame messages
// with sequence wrap, length changes in mid-message and zero-length bytes.
// A scoreboard predicts every CAN frame and checks each output transfer field
// by field. The pad byte is rewritten over the APB port between phases.
// Both channels idle and stall at random, but for one calm phase.
// ----------------------------------------------------------------------------
module tb_isotp_message_segmenter;

    localparam logic [2:0] ADDR_PAD = 3'd0;

    class frame_scoreboard;
        isotp_seg_pkg::t_frame expected_q[$];
        int          errors;
        logic [7:0]  pad;
        logic [11:0] taken;
        logic [3:0]  seq;
        logic [63:0] assembly;
        logic [2:0]  fill;
        logic        first_sent;

        function new();
            errors = 0;
            pad = isotp_seg_pkg::PAD_RESET;
            restart();
        endfunction

        function void restart();
            taken = '0;
            seq = 4'd1;
            assembly = '0;
            fill = '0;
            first_sent = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_frame(logic [10:0] id, int pci_len, logic [15:0] pci, int used,
                                 logic [1:0] kind, logic last);
            isotp_seg_pkg::t_frame f;
            f.frame_payload = (64'(pci) << (64 - 8 * pci_len)) | (assembly >> (8 * pci_len));
            for (int pos = pci_len + used; pos < 8; pos++) begin
                f.frame_payload[63 - 8 * pos -: 8] = pad;
            end
            f.frame_id = id;
            f.frame_kind = kind;
            f.last_frame = last;
            expected_q.push_back(f);
        endfunction

        function void note_byte(logic [7:0] data, logic [11:0] len, logic [10:0] id);
            int   used;
            logic at_end;
            if (len == 0) begin
                return;
            end
            assembly |= 64'(data) << (56 - 8 * int'(fill));
            used = int'(fill) + 1;
            at_end = (13'(taken) + 13'd1 >= 13'(len));
            if (!first_sent && len <= isotp_seg_pkg::SINGLE_MAX) begin
                if (at_end) begin
                    push_frame(id, 1, 16'(len), used, isotp_seg_pkg::KIND_SINGLE, 1'b1);
                    restart();
                end else begin
                    fill = 3'(used);
                    taken = taken + 12'd1;
                end
            end else if (!first_sent) begin
                if (used >= int'(isotp_seg_pkg::FILL_FIRST)) begin
                    push_frame(id, 2, {isotp_seg_pkg::PCI_FIRST, len},
                               int'(isotp_seg_pkg::FILL_FIRST), isotp_seg_pkg::KIND_FIRST,
                               1'b0);
                    first_sent = 1'b1;
                    seq = 4'd1;
                    if (used == int'(isotp_seg_pkg::FILL_CONSEC)) begin
                        assembly = {data, 56'd0};
                        fill = 3'd1;
                    end else begin
                        assembly = '0;
                        fill = '0;
                    end
                    taken = taken + 12'd1;
                end else begin
                    fill = 3'(used);
                    taken = taken + 12'd1;
                end
            end else if (used == int'(isotp_seg_pkg::FILL_CONSEC) || at_end) begin
                push_frame(id, 1, {8'd0, isotp_seg_pkg::PCI_CONSEC, seq}, used,
                           isotp_seg_pkg::KIND_CONSEC, at_end);
                seq = seq + 4'd1;
                assembly = '0;
                fill = '0;
                if (at_end) begin
                    restart();
                end else begin
                    taken = taken + 12'd1;
                end
            end else begin
                fill = 3'(used);
                taken = taken + 12'd1;
            end
        endfunction

        task report(string msg);
            if (errors < 200) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
            errors++;
        endtask

        task check_frame(isotp_seg_pkg::t_frame got);
            isotp_seg_pkg::t_frame want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected frame id %h payload %h", got.frame_id,
                                 got.frame_payload));
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.frame_id != want.frame_id) begin
                report($sformatf("frame_id %h, expected %h", got.frame_id, want.frame_id));
            end
            if (got.frame_payload != want.frame_payload) begin
                report($sformatf("frame_payload %h, expected %h", got.frame_payload,
                                 want.frame_payload));
            end
            if (got.frame_kind != want.frame_kind) begin
                report($sformatf("frame_kind %0d, expected %0d", got.frame_kind,
                                 want.frame_kind));
            end
            if (got.last_frame != want.last_frame) begin
                report($sformatf("last_frame %b, expected %b", got.last_frame,
                                 want.last_frame));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic [11:0] i_msg_length;
    logic [10:0] i_tx_id;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [10:0] o_frame_id;
    logic [63:0] o_frame_payload;
    logic [1:0]  o_frame_kind;
    logic        o_last_frame;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb = new();
    bit calm = 1'b0;
    int items_sent = 0;

    isotp_message_segmenter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_msg_length    (i_msg_length),
        .i_tx_id         (i_tx_id),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_id      (o_frame_id),
        .o_frame_payload (o_frame_payload),
        .o_frame_kind    (o_frame_kind),
        .o_last_frame    (o_last_frame),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready = calm || ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin : frame_monitor
        isotp_seg_pkg::t_frame got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_frame_id, o_frame_payload, o_frame_kind, o_last_frame};
            sb.check_frame(got);
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic [11:0] len,
                             input logic [10:0] id);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 25) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data_byte = data;
        i_msg_length = len;
        i_tx_id = id;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        sb.note_byte(data, len, id);
        if (len != 0) begin
            items_sent++;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_pad(input logic [7:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_PAD;
        pwdata = {24'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sb.pad = value;
        @(negedge i_clk);
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] != value) begin
            sb.report($sformatf("pad_byte read %h, expected %h", prdata[7:0], value));
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic run_messages(input int quota);
        int          target;
        int          pick;
        int          count;
        logic [11:0] len;
        logic [10:0] id;
        target = items_sent + quota;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_byte(8'($urandom), 12'd0, 11'($urandom));
            end else if (pick < 15) begin
                count = $urandom_range(1, 20);
                repeat (count) begin
                    len = $urandom_range(1) ? 12'($urandom_range(1, 4095))
                                            : 12'($urandom_range(1, 12));
                    send_byte(8'($urandom), len, 11'($urandom));
                end
                send_byte(8'($urandom), 12'd1, 11'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    len = 12'($urandom_range(1, 7));
                end else if (pick < 80) begin
                    len = 12'($urandom_range(8, 62));
                end else begin
                    len = 12'($urandom_range(63, 260));
                end
                id = 11'($urandom_range(0, 2047));
                repeat (int'(len)) begin
                    send_byte(8'($urandom), len, id);
                end
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [7:0] pads [5];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_msg_length = '0;
        i_tx_id = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_byte(8'hFF, 12'd0, 11'h7FF);
        send_byte(8'h00, 12'd1, 11'h000);
        repeat (7) send_byte(8'hFF, 12'd7, 11'h7FF);
        for (int i = 0; i < 6; i++) begin
            send_byte(8'(8'h11 * (i + 1)), 12'd7, 11'h123);
        end
        for (int i = 0; i < 3; i++) begin
            send_byte(8'(8'h70 + i), 12'd9, 11'h456);
        end
        send_byte(8'h5A, 12'd4095, 11'h2A5);
        send_byte(8'hA5, 12'd2, 11'h55A);

        pads = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), isotp_seg_pkg::PAD_RESET};
        for (int p = 0; p < 5; p++) begin
            drain();
            write_pad(pads[p]);
            calm = (p == 2);
            run_messages(300);
            calm = 1'b0;
        end
        drain();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
